### src/text_line_format_checker_top_defines.svh
// assertion macros for the text line format checker
`ifndef TEXT_LINE_FORMAT_CHECKER_TOP_DEFINES_SVH
`define TEXT_LINE_FORMAT_CHECKER_TOP_DEFINES_SVH

// clocked assertion, off while reset is high
`define TLFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds around reset
`define TLFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/tlfc_pkg.sv
package tlfc_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned POS_W  = 32;

  // default counter width
  localparam int unsigned COUNTER_WIDTH_DEF = 32;

  // most results one item can cause
  localparam int unsigned RES_MAX = 3;
  localparam int unsigned CNT_W   = 2;

  // result queue sizing
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned OCC_W  = $clog2(QDEPTH + 1);

  // byte classes
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] BYTE_LOW   = 8'd32;
  localparam logic [BYTE_W-1:0] BYTE_HIGH  = 8'd126;

  typedef enum logic [CODE_W-1:0] {
    CODE_ILLEGAL      = 4'd0,
    CODE_TRAIL_SPACE  = 4'd1,
    CODE_LF_NO_CR     = 4'd2,
    CODE_REPEAT_CR    = 4'd3,
    CODE_CR_NO_LF     = 4'd4,
    CODE_REPEAT_LF    = 4'd5,
    CODE_FINAL_UNTERM = 4'd6,
    CODE_FINAL_SPACE  = 4'd7,
    CODE_EMPTY        = 4'd8,
    CODE_END_SCAN     = 4'd9
  } finding_code_t;

  // findings of one item, all at the same position
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    finding_code_t     code0;
    finding_code_t     code1;
    finding_code_t     code2;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  off;
    logic [BYTE_W-1:0] byte_val;
  } bundle_t;

  // one queued result
  typedef struct packed {
    finding_code_t     code;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  off;
    logic [BYTE_W-1:0] byte_val;
    logic              last;
  } result_t;

  // pick a finding code out of a bundle
  function automatic finding_code_t bundle_code(bundle_t b, logic [CNT_W-1:0] idx);
    finding_code_t c;
    case (idx)
      2'd0:    c = b.code0;
      2'd1:    c = b.code1;
      default: c = b.code2;
    endcase
    return c;
  endfunction

endpackage

### src/tlfc_in_if.sv
interface tlfc_in_if;
  import tlfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_marker;

  modport source (output valid, data_byte, end_marker, input ready);
  modport sink   (input valid, data_byte, end_marker, output ready);
endinterface

### src/tlfc_out_if.sv
interface tlfc_out_if;
  import tlfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] finding_code;
  logic [POS_W-1:0]  line_number;
  logic [POS_W-1:0]  column_number;
  logic [POS_W-1:0]  byte_offset;
  logic [BYTE_W-1:0] offending_byte;
  logic              last_result;

  modport source (output valid, finding_code, line_number, column_number, byte_offset,
                  offending_byte, last_result, input ready);
  modport sink   (input valid, finding_code, line_number, column_number, byte_offset,
                  offending_byte, last_result, output ready);
endinterface

### src/text_line_format_checker_top.sv
// Text line format checker: takes one byte of a text file per transaction (or an
// end-of-file marker) and reports formatting findings, each with line, column
// and byte offset, ending every file with an end-of-scan result. A byte is
// taken in every cycle in which the queue has room; the scan state updates on
// acceptance and an item's findings (at most three) pass through the result
// register into an eight-entry result queue that drains one result per cycle
// while the output is ready. The input stalls only while the queue, together
// with the findings in flight, has fewer than three free entries, so throughput
// is one byte per cycle except around bursts of findings or output stalls.
module text_line_format_checker_top #(
  parameter int unsigned COUNTER_WIDTH = tlfc_pkg::COUNTER_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tlfc_in_if.sink    in_ch,
  tlfc_out_if.source out_ch
);
  import tlfc_pkg::*;

`include "text_line_format_checker_top_defines.svh"

  bundle_t bundle;
  result_t head;
  logic    head_valid;
  logic    room;
  logic    accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  // scan state and per-item findings
  tlfc_scan #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .end_marker(in_ch.end_marker),
    .bundle    (bundle)
  );

  // result queue
  tlfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .pop       (out_ch.ready),
    .head      (head),
    .head_valid(head_valid),
    .room      (room)
  );

  // output channel
  assign out_ch.valid          = head_valid;
  assign out_ch.finding_code   = head.code;
  assign out_ch.line_number    = head.line;
  assign out_ch.column_number  = head.col;
  assign out_ch.byte_offset    = head.off;
  assign out_ch.offending_byte = head.byte_val;
  assign out_ch.last_result    = head.last;

  // checks
  `TLFC_ASSERT(a_end_gives_results, accept && in_ch.end_marker |=> bundle.count != '0, "end item gave no results")
  `TLFC_ASSERT_ALWAYS(a_ready_after_reset, $past(rst) |-> in_ch.ready, "not ready after reset")
  `TLFC_ASSERT(a_end_scan_is_last, out_ch.valid && out_ch.finding_code == CODE_END_SCAN |-> out_ch.last_result, "end of scan not marked last")

endmodule

### src/tlfc_scan.sv
module tlfc_scan #(
  parameter int unsigned COUNTER_WIDTH = tlfc_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [tlfc_pkg::BYTE_W-1:0] data_byte,
  input  logic                      end_marker,
  output tlfc_pkg::bundle_t         bundle
);
  import tlfc_pkg::*;

  localparam int unsigned EXT_W = COUNTER_WIDTH + POS_W;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_LINE = 3'b001,
    ST_CR   = 3'b010,
    ST_LF   = 3'b100
  } line_state_t;

  localparam cnt_t CNT_MAX = {COUNTER_WIDTH{1'b1}};
  localparam cnt_t CNT_ONE = COUNTER_WIDTH'(1);

  line_state_t st, st_next;
  cnt_t        line_cnt, line_cnt_next;
  cnt_t        col_cnt, col_cnt_next;
  cnt_t        off_cnt, off_cnt_next;
  logic        prev_space, prev_space_next;
  logic        any_seen, any_seen_next;

  finding_code_t    codes [RES_MAX];
  logic [CNT_W-1:0] n;
  cnt_t             off_pos;
  logic             is_cr, is_lf, illegal, trail;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  // clip a counter to the 32-bit position field
  function automatic logic [POS_W-1:0] clip(cnt_t v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return (|ext[EXT_W-1:POS_W]) ? {POS_W{1'b1}} : ext[POS_W-1:0];
  endfunction

  // byte classes
  assign is_cr   = (data_byte == BYTE_CR);
  assign is_lf   = (data_byte == BYTE_LF);
  assign illegal = ((data_byte < BYTE_LOW) || (data_byte > BYTE_HIGH)) && !is_cr && !is_lf;
  assign trail   = any_seen && prev_space;

  // findings and next state for one item
  always_comb begin
    codes[0]        = CODE_END_SCAN;
    codes[1]        = CODE_END_SCAN;
    codes[2]        = CODE_END_SCAN;
    n               = '0;
    st_next         = st;
    line_cnt_next   = line_cnt;
    col_cnt_next    = col_cnt;
    off_cnt_next    = sat_inc(off_cnt);
    prev_space_next = (data_byte == BYTE_SPACE);
    any_seen_next   = 1'b1;
    off_pos         = off_cnt;

    if (end_marker) begin
      off_pos = (off_cnt != '0) ? off_cnt - CNT_ONE : '0;
      if (!any_seen) begin
        codes[0] = CODE_EMPTY;
        codes[1] = CODE_END_SCAN;
        n        = 2'd2;
      end else begin
        if (st != ST_LF) begin
          codes[n] = CODE_FINAL_UNTERM;
          n        = n + 2'd1;
        end
        if ((st != ST_CR) && (st != ST_LF) && prev_space) begin
          codes[n] = CODE_FINAL_SPACE;
          n        = n + 2'd1;
        end
        codes[n] = CODE_END_SCAN;
        n        = n + 2'd1;
      end
      // back to reset for the next file
      st_next         = ST_LINE;
      line_cnt_next   = CNT_ONE;
      col_cnt_next    = CNT_ONE;
      off_cnt_next    = '0;
      prev_space_next = 1'b0;
      any_seen_next   = 1'b0;
    end else begin
      if (illegal) begin
        codes[n] = CODE_ILLEGAL;
        n        = n + 2'd1;
      end
      case (st)
        ST_CR: begin
          if (is_lf) begin
            line_cnt_next = sat_inc(line_cnt);
            col_cnt_next  = CNT_ONE;
            st_next       = ST_LF;
          end else if (is_cr) begin
            codes[n]     = CODE_REPEAT_CR;
            n            = n + 2'd1;
            col_cnt_next = sat_inc(col_cnt);
          end else begin
            codes[n]     = CODE_CR_NO_LF;
            n            = n + 2'd1;
            col_cnt_next = sat_inc(col_cnt);
          end
        end
        ST_LF: begin
          if (is_lf) begin
            codes[n]      = CODE_REPEAT_LF;
            n             = n + 2'd1;
            line_cnt_next = sat_inc(line_cnt);
            col_cnt_next  = CNT_ONE;
          end else if (is_cr) begin
            col_cnt_next = sat_inc(col_cnt);
            st_next      = ST_CR;
          end else begin
            col_cnt_next = sat_inc(col_cnt);
            st_next      = ST_LINE;
          end
        end
        default: begin
          if (is_lf) begin
            if (trail) begin
              codes[n] = CODE_TRAIL_SPACE;
              n        = n + 2'd1;
            end
            codes[n]      = CODE_LF_NO_CR;
            n             = n + 2'd1;
            line_cnt_next = sat_inc(line_cnt);
            col_cnt_next  = CNT_ONE;
            st_next       = ST_LF;
          end else if (is_cr) begin
            if (trail) begin
              codes[n] = CODE_TRAIL_SPACE;
              n        = n + 2'd1;
            end
            st_next = ST_CR;
          end else begin
            col_cnt_next = sat_inc(col_cnt);
          end
        end
      endcase
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_LINE;
      line_cnt   <= CNT_ONE;
      col_cnt    <= CNT_ONE;
      off_cnt    <= '0;
      prev_space <= 1'b0;
      any_seen   <= 1'b0;
    end else if (accept) begin
      st         <= st_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
      off_cnt    <= off_cnt_next;
      prev_space <= prev_space_next;
      any_seen   <= any_seen_next;
    end
  end

  // result register: count is control and reset, the rest is payload
  always_ff @(posedge clk) begin
    bundle.code0    <= codes[0];
    bundle.code1    <= codes[1];
    bundle.code2    <= codes[2];
    bundle.line     <= clip(line_cnt);
    bundle.col      <= clip(col_cnt);
    bundle.off      <= clip(off_pos);
    bundle.byte_val <= end_marker ? '0 : data_byte;
    if (rst) begin
      bundle.count <= '0;
    end else begin
      bundle.count <= accept ? n : '0;
    end
  end

endmodule

### src/tlfc_queue.sv
module tlfc_queue (
  input  logic              clk,
  input  logic              rst,
  input  tlfc_pkg::bundle_t bundle,
  input  logic              pop,
  output tlfc_pkg::result_t head,
  output logic              head_valid,
  output logic              room
);
  import tlfc_pkg::*;

  result_t          mem [QDEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [OCC_W-1:0] occ;
  logic [OCC_W:0]   fill;
  logic             do_pop;

  // space for a full bundle after the one now in flight
  assign fill       = (OCC_W+1)'(occ) + (OCC_W+1)'(bundle.count);
  assign room       = (fill <= (OCC_W+1)'(QDEPTH - RES_MAX));
  assign head_valid = (occ != '0);
  assign head       = mem[rp];
  assign do_pop     = pop && head_valid;

  // write the findings of one item in order, last flag on the final one
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (CNT_W'(i) < bundle.count) begin
        mem[wp + PTR_W'(i)].code <= bundle_code(bundle, CNT_W'(i));
        mem[wp + PTR_W'(i)].line <= bundle.line;
        mem[wp + PTR_W'(i)].col  <= bundle.col;
        mem[wp + PTR_W'(i)].off  <= bundle.off;
        mem[wp + PTR_W'(i)].byte_val <=
          ((bundle_code(bundle, CNT_W'(i)) == CODE_ILLEGAL) ||
           (bundle_code(bundle, CNT_W'(i)) == CODE_CR_NO_LF)) ? bundle.byte_val : '0;
        mem[wp + PTR_W'(i)].last <= (CNT_W'(i) == bundle.count - CNT_W'(1));
      end
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      occ <= '0;
    end else begin
      wp  <= wp + PTR_W'(bundle.count);
      rp  <= rp + PTR_W'(do_pop);
      occ <= occ + OCC_W'(bundle.count) - OCC_W'(do_pop);
    end
  end

endmodule
